### rtl/core/adpcm_loop_stream_decoder_assert.svh
// Assertion macros for the ADPCM loop stream decoder.
// Needs signals clk and arst_n in the scope where a macro is used.
`ifndef ADPCM_LOOP_STREAM_DECODER_ASSERT_SVH
`define ADPCM_LOOP_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ALSD_ASSERT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define ALSD_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

### rtl/core/alsd_pkg.sv
// Types, constants and the step scale table of the ADPCM loop stream decoder.
// No dependencies.
package alsd_pkg;

	localparam int PosW  = 24;
	localparam int PcmW  = 16;
	localparam int StepW = 15;
	localparam int ScaleW = 10;

	localparam logic [StepW-1:0] STEP_MIN   = 15'd127;
	localparam logic [StepW-1:0] STEP_MAX   = 15'd24576;
	localparam logic [PcmW-1:0]  PCM_MIN    = 16'h8000;
	localparam logic [PcmW-1:0]  PCM_MAX    = 16'h7FFF;

	typedef enum logic [1:0] {
		REG_SAMPLE_COUNT = 2'd0,
		REG_LOOP_ENABLE  = 2'd1,
		REG_LOOP_BEGIN   = 2'd2,
		REG_LOOP_FINISH  = 2'd3
	} reg_idx_t;

	typedef enum logic {
		OP_RESTART = 1'b0,
		OP_DECODE  = 1'b1
	} opcode_t;

	// Step multiplier in 1/256 units, by nibble magnitude.
	function automatic logic [ScaleW-1:0] step_scale(input logic [2:0] mag);
		logic [ScaleW-1:0] s;
		case (mag)
			3'd4:    s = 10'h133;
			3'd5:    s = 10'h199;
			3'd6:    s = 10'h200;
			3'd7:    s = 10'h266;
			default: s = 10'h0E6;
		endcase
		return s;
	endfunction

endpackage

### rtl/core/adpcm_loop_stream_decoder.sv
// From input request accepted to result valid, a request passes the input register,
// then the result register. Throughput: one request per cycle when the output side
// takes results; the decode math between the two registers closes the
// predictor/step feedback combinationally. Reset clears control state, the
// configuration registers and the decoder state (step to 127); no clearing pass.
// Depends on alsd_pkg and adpcm_loop_stream_decoder_assert.svh.
module adpcm_loop_stream_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [23:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [15:0] pcm_sample, [39:16] next_position
	output logic        m_tlast    // ended
);
	import alsd_pkg::*;

	// configuration
	logic [PosW-1:0] count_q, begin_q, finish_q;
	logic            loop_en_q;

	// decoder state
	logic [PcmW-1:0]  pred_q, saved_pred_q;
	logic [StepW-1:0] step_q, saved_step_q;
	logic [PosW-1:0]  pos_q;
	logic             snap_q;

	// input stage
	logic       valid_s1;
	opcode_t    op_s1;
	logic [7:0] byte_s1;

	// result stage
	logic [PcmW-1:0] pcm_s2;
	logic [PosW-1:0] npos_s2;
	logic            ended_s2;

	logic adv;
	assign adv      = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			loop_en_q <= 1'b0;
			begin_q   <= '0;
			finish_q  <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_addr))
				REG_SAMPLE_COUNT: count_q   <= cfg_data;
				REG_LOOP_ENABLE:  loop_en_q <= cfg_data[0];
				REG_LOOP_BEGIN:   begin_q   <= cfg_data;
				REG_LOOP_FINISH:  finish_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// decode datapath
	logic                past_end, snap, rewind;
	logic [3:0]          code;
	logic [2:0]          mag;
	logic [StepW+3:0]    prod_d;
	logic [PcmW-1:0]     delta;
	logic signed [17:0]  sum;
	logic [PcmW-1:0]     pred_sat;
	logic [StepW+ScaleW-1:0] prod_q;
	logic [16:0]         step_raw;
	logic [StepW-1:0]    step_clamp;
	logic [PosW-1:0]     pos_inc;
	logic [PcmW-1:0]     pred_nxt, saved_pred_nxt;
	logic [StepW-1:0]    step_nxt, saved_step_nxt;
	logic [PosW-1:0]     pos_nxt;
	logic                snap_nxt;
	logic [PcmW-1:0]     pcm_nxt;

	always_comb begin
		past_end = !loop_en_q && (pos_q >= count_q);
		snap     = loop_en_q && !snap_q && (pos_q == begin_q);
		code     = pos_q[0] ? byte_s1[7:4] : byte_s1[3:0];
		mag      = code[2:0];

		prod_d = step_q * {15'd0, mag, 1'b1};
		delta  = prod_d[StepW+3:3];
		if (code[3])
			sum = $signed({{2{pred_q[PcmW-1]}}, pred_q}) - $signed({2'b00, delta});
		else
			sum = $signed({{2{pred_q[PcmW-1]}}, pred_q}) + $signed({2'b00, delta});
		if (sum < -18'sd32768)
			pred_sat = PCM_MIN;
		else if (sum > 18'sd32767)
			pred_sat = PCM_MAX;
		else
			pred_sat = sum[PcmW-1:0];

		prod_q   = {{ScaleW{1'b0}}, step_q} * {{StepW{1'b0}}, step_scale(mag)};
		step_raw = prod_q[StepW+ScaleW-1:8];
		if (step_raw < {2'b00, STEP_MIN})
			step_clamp = STEP_MIN;
		else if (step_raw > {2'b00, STEP_MAX})
			step_clamp = STEP_MAX;
		else
			step_clamp = step_raw[StepW-1:0];

		pos_inc = pos_q + 24'd1;
		rewind  = loop_en_q && (pos_inc >= finish_q);

		saved_pred_nxt = snap ? pred_q : saved_pred_q;
		saved_step_nxt = snap ? step_q : saved_step_q;
		snap_nxt       = snap_q || snap;

		// defaults: state unchanged
		pred_nxt = pred_q;
		step_nxt = step_q;
		pos_nxt  = pos_q;
		pcm_nxt  = '0;
		if (op_s1 == OP_RESTART) begin
			pred_nxt       = '0;
			step_nxt       = STEP_MIN;
			pos_nxt        = '0;
			saved_pred_nxt = '0;
			saved_step_nxt = '0;
			snap_nxt       = 1'b0;
		end else if (past_end) begin
			saved_pred_nxt = saved_pred_q;
			saved_step_nxt = saved_step_q;
			snap_nxt       = snap_q;
		end else begin
			pcm_nxt = pred_sat;
			if (rewind) begin
				// restore uses a snapshot taken by this very sample too
				pred_nxt = saved_pred_nxt;
				step_nxt = saved_step_nxt;
				pos_nxt  = begin_q;
			end else begin
				pred_nxt = pred_sat;
				step_nxt = step_clamp;
				pos_nxt  = pos_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pred_q       <= '0;
			step_q       <= STEP_MIN;
			pos_q        <= '0;
			saved_pred_q <= '0;
			saved_step_q <= '0;
			snap_q       <= 1'b0;
		end else if (adv) begin
			pred_q       <= pred_nxt;
			step_q       <= step_nxt;
			pos_q        <= pos_nxt;
			saved_pred_q <= saved_pred_nxt;
			saved_step_q <= saved_step_nxt;
			snap_q       <= snap_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1   <= opcode_t'(s_tuser);
			byte_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pcm_s2   <= pcm_nxt;
			npos_s2  <= pos_nxt;
			ended_s2 <= !loop_en_q && (pos_nxt >= count_q);
		end
	end

	assign m_tdata = {npos_s2, pcm_s2};
	assign m_tlast = ended_s2;

`include "adpcm_loop_stream_decoder_assert.svh"

	`ALSD_ASSERT(a_step_max, 1'b1, step_q <= STEP_MAX, "step above maximum")
	`ALSD_ASSERT(a_stall_holds, m_tvalid && !m_tready && valid_s1, !s_tready, "input taken over stalled request")
	`ALSD_ASSERT_NEXT(a_restart_clears, adv && op_s1 == OP_RESTART, pos_q == '0 && !snap_q && step_q == STEP_MIN, "restart did not clear state")
	`ALSD_ASSERT_NEXT(a_result_valid, adv, m_tvalid, "processed request gave no result")

endmodule

### sim/tb_adpcm_loop_stream_decoder.sv
// Self-checking bench for adpcm_loop_stream_decoder: directed rows, then random phases
// of configuration and nibble streams, each result checked against an in-bench predictor or a pinned value.
// Depends on alsd_pkg and the decoder RTL.
module tb_adpcm_loop_stream_decoder;
	import alsd_pkg::*;

	localparam int RandItems  = 1650;
	localparam int MaxGap     = 18;
	localparam int SettleCyc  = 4;
	localparam int StallLimit = 2000;

	typedef struct packed {
		logic            ended;
		logic [PosW-1:0] pos;
		logic [PcmW-1:0] pcm;
	} sample_t;

	typedef struct {
		bit          is_cfg;
		reg_idx_t    idx;
		logic [23:0] val;
		opcode_t     op;
		logic [7:0]  dbyte;
		bit          pinned;
		sample_t     pin;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_addr = '0;
	logic [23:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tlast;

	adpcm_loop_stream_decoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always #4 clk = ~clk;

	// predictor copy of the configuration and decoder state
	logic [23:0]        cfg_count, cfg_begin, cfg_finish;
	logic               cfg_loop;
	logic signed [15:0] dec_pred, snap_pred;
	logic [14:0]        dec_step, snap_step;
	logic [23:0]        dec_pos;
	logic               snap_valid;

	sample_t pending_samples[$];
	row_t    directed[$];
	int      src_mode, snk_mode;
	int      errors = 0;
	int      n_items = 0;
	int      n_restarts = 0;
	int      n_results = 0;
	int      n_phases = 0;
	int      n_loop_phases = 0;
	int      quiet = 0;

	function automatic logic exhausted();
		return !cfg_loop && dec_pos >= cfg_count;
	endfunction

	function automatic sample_t adpcm_expected_sample(input opcode_t op, input logic [7:0] b);
		sample_t    r;
		logic [3:0] nib;
		int         delta, acc, nstep, mult;
		if (op == OP_RESTART) begin
			dec_pred = '0;
			dec_step = STEP_MIN;
			dec_pos = '0;
			snap_pred = '0;
			snap_step = '0;
			snap_valid = 1'b0;
			r.pcm = '0;
			r.pos = '0;
			r.ended = exhausted();
			return r;
		end
		// one-shot source used up: nothing moves
		if (exhausted()) begin
			r.pcm = '0;
			r.pos = dec_pos;
			r.ended = 1'b1;
			return r;
		end
		if (cfg_loop && !snap_valid && dec_pos == cfg_begin) begin
			snap_pred = dec_pred;
			snap_step = dec_step;
			snap_valid = 1'b1;
		end
		nib = dec_pos[0] ? b[7:4] : b[3:0];
		delta = (int'(dec_step) * (2 * int'(nib[2:0]) + 1)) >>> 3;
		if (nib[3])
			delta = -delta;
		acc = int'(dec_pred) + delta;
		if (acc < $signed(PCM_MIN))
			acc = $signed(PCM_MIN);
		else if (acc > $signed(PCM_MAX))
			acc = $signed(PCM_MAX);
		dec_pred = acc[15:0];
		case (nib[2:0])
			3'd4:    mult = 'h133;
			3'd5:    mult = 'h199;
			3'd6:    mult = 'h200;
			3'd7:    mult = 'h266;
			default: mult = 'h0E6;
		endcase
		nstep = (int'(dec_step) * mult) >>> 8;
		if (nstep < int'(STEP_MIN))
			nstep = int'(STEP_MIN);
		else if (nstep > int'(STEP_MAX))
			nstep = int'(STEP_MAX);
		dec_step = nstep[14:0];
		dec_pos = dec_pos + 1'b1;
		// rewind restores whatever was saved, even if loop start was never hit
		if (cfg_loop && dec_pos >= cfg_finish) begin
			dec_pred = snap_pred;
			dec_step = snap_step;
			dec_pos = cfg_begin;
		end
		r.pcm = acc[15:0];
		r.pos = dec_pos;
		r.ended = exhausted();
		return r;
	endfunction

	function automatic int draw_gap(input int mode);
		case (mode)
			0:       return 0;
			1:       return $urandom_range(0, MaxGap);
			default: return ($urandom_range(0, 4) == 0) ? $urandom_range(1, MaxGap) : 0;
		endcase
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0:       return 8'h77;
			1:       return 8'hFF;
			2:       return 8'h00;
			3:       return 8'h88;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic row_t cfg_row(input reg_idx_t idx, input logic [23:0] v);
		row_t r;
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.val = v;
		r.op = OP_DECODE;
		r.dbyte = '0;
		r.pinned = 1'b0;
		r.pin = '0;
		return r;
	endfunction

	function automatic row_t item_row(input opcode_t op, input logic [7:0] b);
		row_t r;
		r.is_cfg = 1'b0;
		r.idx = REG_SAMPLE_COUNT;
		r.val = '0;
		r.op = op;
		r.dbyte = b;
		r.pinned = 1'b0;
		r.pin = '0;
		return r;
	endfunction

	// row whose result is known outright: pcm is 0 in all of these
	function automatic row_t pinned_row(input opcode_t op, input logic [7:0] b,
			input logic [23:0] pos, input logic ended);
		row_t r;
		r = item_row(op, b);
		r.pinned = 1'b1;
		r.pin.pcm = '0;
		r.pin.pos = pos;
		r.pin.ended = ended;
		return r;
	endfunction

	task automatic program_reg(input reg_idx_t idx, input logic [23:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		case (idx)
			REG_SAMPLE_COUNT: cfg_count = val;
			REG_LOOP_ENABLE:  cfg_loop = val[0];
			REG_LOOP_BEGIN:   cfg_begin = val;
			REG_LOOP_FINISH:  cfg_finish = val;
			default: ;
		endcase
	endtask

	// hold requests until every result is back and the pipeline is empty
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_samples.size() != 0)
			@(negedge clk);
		repeat (SettleCyc) @(negedge clk);
	endtask

	task automatic send_item(input opcode_t op, input logic [7:0] b, input bit pinned,
			input sample_t pin);
		int      gap;
		sample_t want;
		gap = draw_gap(src_mode);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		want = adpcm_expected_sample(op, b);
		pending_samples.push_back(pinned ? pin : want);
		n_items++;
		if (op == OP_RESTART)
			n_restarts++;
		@(negedge clk);
	endtask

	task automatic configure_phase(input int kind);
		logic [23:0] cnt, lb, lf;
		logic        le;
		cnt = 24'($urandom_range(0, 150));
		le = 1'b0;
		lb = 24'($urandom_range(0, 100));
		lf = 24'($urandom_range(0, 200));
		case (kind)
			1: begin
				cnt = 24'($urandom);
				lb = 24'($urandom);
				lf = 24'($urandom);
			end
			2, 3, 7: begin
				le = 1'b1;
				lb = 24'($urandom_range(0, 40));
				lf = lb + 24'($urandom_range(1, 60));
			end
			4: begin
				// finish may sit below begin or at zero
				le = 1'b1;
				lf = 24'($urandom_range(0, 100));
			end
			5: begin
				// loop start near the top so the position wraps
				le = 1'b1;
				lb = 24'hFFFFFF - 24'($urandom_range(0, 3));
				lf = 24'($urandom_range(1, 30));
			end
			6: begin
				le = 1'($urandom_range(0, 1));
				cnt = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h0;
				lb = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h0;
				lf = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h0;
			end
			default: ;
		endcase
		program_reg(REG_SAMPLE_COUNT, cnt);
		program_reg(REG_LOOP_ENABLE, {23'd0, le});
		program_reg(REG_LOOP_BEGIN, lb);
		program_reg(REG_LOOP_FINISH, lf);
		if (le)
			n_loop_phases++;
	endtask

	// result checker
	sample_t got, want_s;
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got.pcm = m_tdata[15:0];
			got.pos = m_tdata[39:16];
			got.ended = m_tlast;
			n_results++;
			if (pending_samples.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("result %0d arrived with nothing outstanding: pcm %0d next %0d ended %0b",
						n_results, $signed(got.pcm), got.pos, got.ended);
			end else begin
				want_s = pending_samples.pop_front();
				if (got.pcm !== want_s.pcm || got.pos !== want_s.pos || got.ended !== want_s.ended) begin
					errors++;
					if (errors <= 10)
						$display("result %0d: expected pcm %0d next %0d ended %0b, got pcm %0d next %0d ended %0b",
							n_results, $signed(want_s.pcm), want_s.pos, want_s.ended,
							$signed(got.pcm), got.pos, got.ended);
				end
			end
		end
	end

	// watchdog on handshake activity
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet <= 0;
		end else if (quiet == StallLimit) begin
			$display("no request moved for %0d cycles, %0d results outstanding",
				StallLimit, pending_samples.size());
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// result side back-pressure
	initial begin
		int gap;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = draw_gap(snk_mode);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	initial begin
		int      n, kind, len;
		opcode_t op;
		cfg_count = '0;
		cfg_loop = 1'b0;
		cfg_begin = '0;
		cfg_finish = '0;
		// reset leaves the decoder as a restart does
		void'(adpcm_expected_sample(OP_RESTART, 8'h00));
		src_mode = 1;
		snk_mode = 2;

		// reset config: empty one-shot source
		directed.push_back(pinned_row(OP_DECODE, 8'h5A, 24'd0, 1'b1));
		directed.push_back(pinned_row(OP_RESTART, 8'h00, 24'd0, 1'b1));
		// drive to positive then negative saturation, step to its ceiling
		directed.push_back(cfg_row(REG_SAMPLE_COUNT, 24'hFFFFFF));
		repeat (7) directed.push_back(item_row(OP_DECODE, 8'h77));
		repeat (3) directed.push_back(item_row(OP_DECODE, 8'hFF));
		directed.push_back(item_row(OP_DECODE, 8'h08));
		// short one-shot source, then a decode past the end
		directed.push_back(cfg_row(REG_SAMPLE_COUNT, 24'd3));
		directed.push_back(pinned_row(OP_RESTART, 8'hC3, 24'd0, 1'b0));
		repeat (3) directed.push_back(item_row(OP_DECODE, 8'h12));
		directed.push_back(pinned_row(OP_DECODE, 8'hEE, 24'd3, 1'b1));
		// rewind before loop start is seen, then wrap from the top position
		directed.push_back(cfg_row(REG_LOOP_ENABLE, 24'd1));
		directed.push_back(cfg_row(REG_LOOP_BEGIN, 24'hFFFFFF));
		directed.push_back(cfg_row(REG_LOOP_FINISH, 24'd2));
		directed.push_back(pinned_row(OP_RESTART, 8'h00, 24'd0, 1'b0));
		repeat (3) directed.push_back(item_row(OP_DECODE, 8'h3C));
		// zero loop finish: every decode rewinds
		directed.push_back(cfg_row(REG_LOOP_FINISH, 24'd0));
		directed.push_back(cfg_row(REG_LOOP_BEGIN, 24'd5));
		repeat (2) directed.push_back(item_row(OP_DECODE, 8'hA5));

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[i]) begin
			if (directed[i].is_cfg) begin
				settle();
				program_reg(directed[i].idx, directed[i].val);
			end else begin
				send_item(directed[i].op, directed[i].dbyte, directed[i].pinned, directed[i].pin);
			end
		end

		n = n_items + RandItems;
		while (n_items < n) begin
			kind = $urandom_range(0, 7);
			settle();
			src_mode = $urandom_range(0, 2);
			snk_mode = $urandom_range(0, 2);
			configure_phase(kind);
			if ($urandom_range(0, 3) != 0)
				send_item(OP_RESTART, 8'($urandom_range(0, 255)), 1'b0, '0);
			len = $urandom_range(20, 200);
			for (int k = 0; k < len && n_items < n; k++) begin
				// one mid-stream drain of all outstanding requests
				if (n_phases == 2 && k == len / 2)
					settle();
				op = ($urandom_range(0, 49) == 0) ? OP_RESTART : OP_DECODE;
				send_item(op, pick_byte(), 1'b0, '0);
			end
			n_phases++;
		end

		settle();
		repeat (8) @(negedge clk);
		$display("covered %0d requests (%0d restarts) in %0d random phases, %0d with looping",
			n_items, n_restarts, n_phases, n_loop_phases);
		$display("%0d results checked, %0d mismatches", n_results, errors);
		if (errors == 0 && pending_samples.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/alsd_pkg.sv
rtl/core/adpcm_loop_stream_decoder.sv
sim/tb_adpcm_loop_stream_decoder.sv
